/* design/scancode_set1_to_hid_key_tracker_core_defines.svh */
// Assertion macros for the scan code tracker checker.
// The enclosing module must provide clk_i and rst_ni.
`ifndef SCANCODE_SET1_TO_HID_KEY_TRACKER_CORE_DEFINES_SVH
`define SCANCODE_SET1_TO_HID_KEY_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SC2H_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SC2H_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sc2h_pkg.sv */
package sc2h_pkg;

  // Scan code constants
  localparam logic [7:0] PfxExt     = 8'hE0;
  localparam logic [7:0] PfxPause   = 8'hE1;
  localparam int unsigned RelBit    = 7;
  localparam logic [7:0] PauseUsage = 8'h48;

  // Output item layout
  localparam int unsigned UsageW   = 8;
  localparam int unsigned MapW     = 256;
  localparam int unsigned OutUsedW = UsageW + 1 + MapW;
  localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;

  // Prefix tracking states of the front end
  typedef enum logic [1:0] {
    FS_IDLE,
    FS_EXT,
    FS_PAUSE1,
    FS_PAUSE2
  } front_state_e;

  // Classified key code passed from front to back
  typedef struct packed {
    logic       pause;    // E1 sequence, fixed pause usage
    logic [7:0] rom_idx;  // translation table index
    logic       pressed;
  } code_t;

  // Set-1 to HID usage table: low half plain codes, upper half E0 codes
  localparam logic [7:0] UsageRom [256] = '{
    8'h00,8'h29,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,8'h2d,8'h2e,8'h2a,8'h2b,
    8'h14,8'h1a,8'h08,8'h15,8'h17,8'h1c,8'h18,8'h0c,8'h12,8'h13,8'h2f,8'h30,8'h28,8'he0,8'h04,8'h16,
    8'h07,8'h09,8'h0a,8'h0b,8'h0d,8'h0e,8'h0f,8'h33,8'h34,8'h35,8'he1,8'h31,8'h1d,8'h1b,8'h06,8'h19,
    8'h05,8'h11,8'h10,8'h36,8'h37,8'h38,8'he5,8'h55,8'he2,8'h2c,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,
    8'h3f,8'h40,8'h41,8'h42,8'h43,8'h53,8'h47,8'h5f,8'h60,8'h61,8'h56,8'h5c,8'h5d,8'h5e,8'h57,8'h59,
    8'h5a,8'h5b,8'h62,8'h63,8'h00,8'h00,8'h64,8'h44,8'h45,8'h67,8'h00,8'h00,8'h8c,8'h68,8'h69,8'h6a,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h88,8'h00,8'h00,8'h87,8'h00,8'h00,8'h94,8'h93,8'h92,8'h8a,8'h00,8'h8b,8'h00,8'h89,8'h85,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h58,8'he4,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h54,8'h00,8'h46,8'he6,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h48,8'h4a,8'h52,8'h4b,8'h00,8'h50,8'h00,8'h4f,8'h00,8'h4d,
    8'h51,8'h4e,8'h49,8'h4c,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'he3,8'he7,8'h65,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

endpackage

/* design/sc2h_front.sv */
module sc2h_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_valid_i,
  output logic            byte_ready_o,
  input  logic [7:0]      byte_i,
  output logic            code_valid_o,
  input  logic            code_ready_i,
  output sc2h_pkg::code_t code_o
);
  import sc2h_pkg::*;

  front_state_e state_q, state_d;
  logic         pause_rel_q, pause_rel_d;
  logic         accept;

  // A byte is taken whenever the queue has room for a possible code
  assign byte_ready_o = code_ready_i;
  assign accept       = byte_valid_i && code_ready_i;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      pause_rel_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pause_rel_q <= pause_rel_d;
    end
  end

  // Prefix tracking and code classification
  always_comb begin
    state_d      = state_q;
    pause_rel_d  = pause_rel_q;
    code_valid_o = 1'b0;
    code_o       = '{pause: 1'b0, rom_idx: {1'b0, byte_i[6:0]}, pressed: !byte_i[RelBit]};
    if (accept) begin
      case (state_q)
        FS_IDLE: begin
          if (byte_i == PfxExt) begin
            state_d = FS_EXT;
          end else if (byte_i == PfxPause) begin
            state_d = FS_PAUSE1;
          end else begin
            code_valid_o = 1'b1;
          end
        end
        FS_EXT: begin
          code_o.rom_idx = {1'b1, byte_i[6:0]};
          code_valid_o   = 1'b1;
          state_d        = FS_IDLE;
        end
        FS_PAUSE1: begin
          pause_rel_d = byte_i[RelBit];
          state_d     = FS_PAUSE2;
        end
        FS_PAUSE2: begin
          code_o.pause   = 1'b1;
          code_o.pressed = !pause_rel_q;
          code_valid_o   = 1'b1;
          state_d        = FS_IDLE;
        end
        default: begin
          state_d = FS_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/sc2h_fifo.sv */
module sc2h_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  sc2h_pkg::code_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output sc2h_pkg::code_t pop_data_o
);
  import sc2h_pkg::*;

  // Two-slot queue between classifier and map update
  code_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* design/sc2h_back.sv */
module sc2h_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            code_valid_i,
  output logic                            code_ready_o,
  input  sc2h_pkg::code_t                 code_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sc2h_pkg::OutDataW-1:0]   out_data_o
);
  import sc2h_pkg::*;

  logic [MapW-1:0]   map_q, map_d;
  logic              valid_q, valid_d;
  logic [UsageW-1:0] usage_q, usage_w;
  logic              pressed_q;
  logic [MapW-1:0]   usage_bit;
  logic              take;

  // Output register frees when empty or being drained
  assign code_ready_o = !valid_q || out_ready_i;
  assign take         = code_valid_i && code_ready_o;

  // Table lookup and map update
  assign usage_w   = code_i.pause ? PauseUsage : UsageRom[code_i.rom_idx];
  assign usage_bit = MapW'(1) << usage_w;
  assign map_d     = code_i.pressed ? (map_q | usage_bit) : (map_q & ~usage_bit);

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Control and held-key map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      map_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (take) map_q <= map_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      usage_q   <= usage_w;
      pressed_q <= code_i.pressed;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {(OutDataW - OutUsedW)'(0), map_q, pressed_q, usage_q};

endmodule

/* design/scancode_set1_to_hid_key_tracker_core.sv */
// Scan code set 1 to HID usage translator with a 256-key held map.
// Input stream (s_axis): one keyboard byte per item. E0 and E1 prefix bytes
// are absorbed and produce no result; the completing byte of a code does.
// Output stream (m_axis): one item per completed code with the HID usage,
// the press flag and the whole held-key map after the update.
// Path: a completing byte enters the two-slot code queue at the accepting
// edge and moves on into the output register before it shows up on m_axis.
// Throughput: one byte per cycle while the code queue has room; the table
// lookup and map update in the back end are combinational.
// Reset: the prefix tracker goes idle, the queue empties, the output valid
// drops and the held map clears to no keys held.
// Stall: while m_axis_tready is low the output item holds; the front keeps
// taking bytes until the queue fills, then drops s_axis_tready.
module scancode_set1_to_hid_key_tracker_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] scan_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] usage_code, [8] pressed, [72:9] held_keys_0, [136:73] held_keys_1,
  // [200:137] held_keys_2, [264:201] held_keys_3, [271:265] zero
  output logic [sc2h_pkg::OutDataW-1:0]   m_axis_tdata
);
  import sc2h_pkg::*;

  logic  fr_valid, fr_ready;
  code_t fr_code;
  logic  bk_valid, bk_ready;
  code_t bk_code;

  // Prefix tracking and classification
  sc2h_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .code_valid_o (fr_valid),
    .code_ready_i (fr_ready),
    .code_o       (fr_code)
  );

  // Code queue
  sc2h_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_code),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_code)
  );

  // Translation and held map
  sc2h_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_valid_i (bk_valid),
    .code_ready_o (bk_ready),
    .code_i       (bk_code),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule

/* design/sc2h_checker.sv */
`include "scancode_set1_to_hid_key_tracker_core_defines.svh"

module sc2h_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sc2h_pkg::OutDataW-1:0] m_axis_tdata
);
  import sc2h_pkg::*;

  logic [MapW-1:0]   out_map;
  logic [UsageW-1:0] out_usage;
  logic              out_pressed;

  assign out_map     = m_axis_tdata[OutUsedW-1:UsageW+1];
  assign out_usage   = m_axis_tdata[UsageW-1:0];
  assign out_pressed = m_axis_tdata[UsageW];

  // Stalled output item holds
  `SC2H_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output item changed under stall")

  // Map reflects a press of the reported usage
  `SC2H_ASSERT_NOW(a_press_set, m_axis_tvalid && out_pressed, out_map[out_usage], "pressed usage not held in map")

  // Map reflects a release of the reported usage
  `SC2H_ASSERT_NOW(a_release_clr, m_axis_tvalid && !out_pressed, !out_map[out_usage], "released usage still held in map")

  // Pad bits above the map stay zero
  `SC2H_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OutDataW-1:OutUsedW] == '0, "nonzero pad bits on output")

  // Queue can only be full behind a waiting output item
  `SC2H_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled with no output waiting")

endmodule

bind scancode_set1_to_hid_key_tracker_core sc2h_checker u_sc2h_checker (.*);
